// ----- design/nbdg_pkg.sv -----
// shared types, widths, codes and reset values of the direct-sum gravity engine
package nbdg_pkg;

  localparam int POS_W   = 32;
  localparam int MASS_W  = 32;
  localparam int G_W     = 48;
  localparam int SOFT_W  = 32;
  localparam int CNT_W   = 11;
  localparam int SLOT_W  = 10;
  localparam int FORCE_W = 48;
  localparam int CFG_W   = 48;
  localparam int CFG_AW  = 2;

  localparam int DIFF_W  = POS_W + 1;
  localparam int MAG_W   = DIFF_W;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int ROOT_W  = SQ_W / 2 + 1;
  localparam int RAD_W   = 2 * ROOT_W;
  localparam int SQR_REM_W = ROOT_W + 2;
  localparam int D_W     = ROOT_W + 1;
  localparam int D2_W    = 2 * D_W;
  localparam int DEN_W   = 3 * D_W;
  localparam int GM1_W   = G_W + MASS_W;
  localparam int GM_W    = GM1_W + MASS_W;
  localparam int P_W     = GM_W + MAG_W;
  localparam int FRAC_SH = 8;
  localparam int Q_W     = FORCE_W - 1;
  localparam int DIV_REM_W = P_W + FRAC_SH - Q_W;

  localparam int MUL_LIMB_W = 32;
  localparam int MUL_LIMBS  = 4;
  localparam int MUL_A_W    = MUL_LIMB_W * MUL_LIMBS;
  localparam int MUL_B_W    = 36;
  localparam int MUL_P_W    = MUL_A_W + MUL_B_W;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [CFG_AW-1:0] CFG_COUNT = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_GRAV  = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_SOFT  = 2'd2;

  localparam logic [CNT_W-1:0]  CNT_RST  = 11'd1024;
  localparam logic [G_W-1:0]    GRAV_RST = 48'd549755814;
  localparam logic [SOFT_W-1:0] SOFT_RST = 32'd167772;

  localparam logic [FORCE_W-1:0] F_POS_MAX = {1'b0, {(FORCE_W-1){1'b1}}};
  localparam logic [FORCE_W-1:0] F_NEG_MIN = {1'b1, {(FORCE_W-1){1'b0}}};

  localparam logic [2:0] MUL_AXAX = 3'd0;
  localparam logic [2:0] MUL_AYAY = 3'd1;
  localparam logic [2:0] MUL_DD   = 3'd2;
  localparam logic [2:0] MUL_DDD  = 3'd3;
  localparam logic [2:0] MUL_G1   = 3'd4;
  localparam logic [2:0] MUL_G2   = 3'd5;
  localparam logic [2:0] MUL_PX   = 3'd6;
  localparam logic [2:0] MUL_PY   = 3'd7;

  typedef struct packed {
    logic       accept;
    logic       rd;
    logic       diff;
    logic       idx_inc;
    logic       mul_go;
    logic [2:0] mul_sel;
    logic       sqrt_go;
    logic       div_go;
    logic       div_y;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic skip;
    logic d_zero;
    logic mul_done;
    logic sqrt_done;
    logic div_done;
  } status_t;

endpackage

// ----- design/nbdg_mul.sv -----
// multi-cycle wide multiplier, one 32-bit limb of the wide operand per cycle
module nbdg_mul (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        go_i,
  input  logic [nbdg_pkg::MUL_A_W-1:0] a_i,
  input  logic [nbdg_pkg::MUL_B_W-1:0] b_i,
  output logic [nbdg_pkg::MUL_P_W-1:0] p_o,
  output logic                        done_o
);
  import nbdg_pkg::*;

  localparam int LCW = $clog2(MUL_LIMBS);
  localparam int PP_W = MUL_LIMB_W + MUL_B_W;

  logic               busy_q;
  logic [LCW-1:0]     cnt_q;
  logic               done_q;
  logic [MUL_A_W-1:0] a_q;
  logic [MUL_B_W-1:0] b_q;
  logic [MUL_P_W-1:0] acc_q;
  logic [PP_W-1:0]    pp;

  assign pp = PP_W'(a_q[cnt_q*MUL_LIMB_W +: MUL_LIMB_W]) * PP_W'(b_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LCW'(MUL_LIMBS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_q + (MUL_P_W'(pp) << (cnt_q * MUL_LIMB_W));
    end
  end

  assign p_o    = acc_q;
  assign done_o = done_q;

endmodule

// ----- design/nbdg_sqrt.sv -----
// bit-serial integer square root, one result bit per cycle
module nbdg_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       go_i,
  input  logic [nbdg_pkg::RAD_W-1:0]  rad_i,
  output logic [nbdg_pkg::ROOT_W-1:0] root_o,
  output logic                       done_o
);
  import nbdg_pkg::*;

  localparam int CW = $clog2(ROOT_W + 1);
  localparam int T_W = SQR_REM_W + 2;

  logic                 run_q;
  logic [CW-1:0]        cnt_q;
  logic                 done_q;
  logic [RAD_W-1:0]     rad_q;
  logic [SQR_REM_W-1:0] rem_q;
  logic [ROOT_W-1:0]    root_q;
  logic [T_W-1:0]       rem_t;
  logic [T_W-1:0]       trial;
  logic                 ge;

  assign rem_t = {rem_q, rad_q[RAD_W-1 -: 2]};
  assign trial = T_W'({root_q, 2'b01});
  assign ge    = rem_t >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(ROOT_W - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (run_q) begin
      rad_q  <= rad_q << 2;
      rem_q  <= ge ? SQR_REM_W'(rem_t - trial) : SQR_REM_W'(rem_t);
      root_q <= {root_q[ROOT_W-2:0], ge};
    end
  end

  assign root_o = root_q;
  assign done_o = done_q;

endmodule

// ----- design/nbdg_div.sv -----
// restoring divider for one force term, with early clamp when the quotient overflows
module nbdg_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      go_i,
  input  logic [nbdg_pkg::P_W-1:0]   p_i,
  input  logic [nbdg_pkg::DEN_W-1:0] den_i,
  output logic [nbdg_pkg::Q_W-1:0]   q_o,
  output logic                      sat_o,
  output logic                      done_o
);
  import nbdg_pkg::*;

  localparam int CW = $clog2(Q_W + 1);
  localparam int LOW_SH = Q_W - FRAC_SH;

  logic                 chk_q;
  logic                 run_q;
  logic [CW-1:0]        cnt_q;
  logic                 done_q;
  logic [DIV_REM_W-1:0] rem_q;
  logic [Q_W-1:0]       low_q;
  logic [DEN_W-1:0]     den_q;
  logic [Q_W-1:0]       q_q;
  logic                 sat_q;
  logic [DIV_REM_W-1:0] den_ext;
  logic [DIV_REM_W-1:0] rem_t;
  logic                 ovf;
  logic                 ge;

  assign den_ext = DIV_REM_W'(den_q);
  assign ovf     = rem_q >= den_ext;
  assign rem_t   = {rem_q[DIV_REM_W-2:0], low_q[Q_W-1]};
  assign ge      = rem_t >= den_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chk_q  <= 1'b0;
      run_q  <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        chk_q <= 1'b1;
        run_q <= 1'b0;
      end else if (chk_q) begin
        chk_q <= 1'b0;
        cnt_q <= '0;
        if (ovf) begin
          done_q <= 1'b1;
        end else begin
          run_q <= 1'b1;
        end
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(Q_W - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      rem_q <= DIV_REM_W'(p_i >> LOW_SH);
      low_q <= {p_i[LOW_SH-1:0], {FRAC_SH{1'b0}}};
      den_q <= den_i;
      q_q   <= '0;
      sat_q <= 1'b0;
    end else if (chk_q) begin
      if (ovf) begin
        sat_q <= 1'b1;
        q_q   <= '1;
      end
    end else if (run_q) begin
      rem_q <= ge ? rem_t - den_ext : rem_t;
      low_q <= low_q << 1;
      q_q   <= {q_q[Q_W-2:0], ge};
    end
  end

  assign q_o    = q_q;
  assign sat_o  = sat_q;
  assign done_o = done_q;

endmodule

// ----- design/nbdg_dp.sv -----
// datapath: configuration registers, particle store, arithmetic units and force sums
module nbdg_dp #(
  parameter int MAX_PARTICLES = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  nbdg_pkg::cmd_t                     cmd_i,
  output nbdg_pkg::status_t                  status_o,
  input  logic                               cfg_we_i,
  input  logic [nbdg_pkg::CFG_AW-1:0]        cfg_addr_i,
  input  logic [nbdg_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  logic                               opcode_i,
  input  logic [nbdg_pkg::SLOT_W-1:0]        slot_i,
  input  logic signed [nbdg_pkg::POS_W-1:0]  pos_x_i,
  input  logic signed [nbdg_pkg::POS_W-1:0]  pos_y_i,
  input  logic [nbdg_pkg::MASS_W-1:0]        mass_i,
  output logic signed [nbdg_pkg::FORCE_W-1:0] force_x_o,
  output logic signed [nbdg_pkg::FORCE_W-1:0] force_y_o,
  output logic                               saturated_o
);
  import nbdg_pkg::*;

  localparam int AW = $clog2(MAX_PARTICLES);
  localparam int IW = $clog2(MAX_PARTICLES + 1);
  localparam int ENT_W = 2 * POS_W + MASS_W;

  logic [CNT_W-1:0]  cnt_q;
  logic [G_W-1:0]    grav_q;
  logic [SOFT_W-1:0] soft_q;

  logic [ENT_W-1:0]  mem [MAX_PARTICLES];
  logic [ENT_W-1:0]  rd_q;
  logic [IW-1:0]     idx_q;
  logic [IW-1:0]     n_w;
  logic              slot_ok;
  logic              query_go;

  logic [POS_W-1:0]  px_q, py_q;
  logic [MASS_W-1:0] pm_q;
  logic [POS_W-1:0]  sx, sy;
  logic [MASS_W-1:0] sm;
  logic [DIFF_W-1:0] rx_w, ry_w;
  logic [MAG_W-1:0]  ax_w, ay_w, ax_q, ay_q;
  logic              rx_neg_q, ry_neg_q;

  logic [SQ_W-1:0]   sq_q;
  logic [D_W-1:0]    d_q;
  logic [D2_W-1:0]   d2_q;
  logic [DEN_W-1:0]  den_q;
  logic [GM_W-1:0]   gm_q;
  logic [P_W-1:0]    p_q;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;
  logic               mul_done;
  logic [ROOT_W-1:0]  sqrt_root;
  logic               sqrt_done;
  logic [Q_W-1:0]     div_q;
  logic               div_sat;
  logic               div_done;

  logic signed [FORCE_W-1:0] fx_q, fy_q;
  logic                      sat_q;
  logic signed [FORCE_W:0]   term_w, acc_ext, sum_w;
  logic [FORCE_W-1:0]        sum_sat;
  logic                      ovf;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= CNT_RST;
      grav_q <= GRAV_RST;
      soft_q <= SOFT_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_COUNT: cnt_q  <= cfg_wdata_i[CNT_W-1:0];
        CFG_GRAV:  grav_q <= cfg_wdata_i[G_W-1:0];
        CFG_SOFT:  soft_q <= cfg_wdata_i[SOFT_W-1:0];
        default: ;
      endcase
    end
  end

  assign n_w = (32'(cnt_q) > 32'(MAX_PARTICLES)) ? IW'(MAX_PARTICLES) : IW'(cnt_q);
  assign slot_ok  = 32'(slot_i) < 32'(MAX_PARTICLES);
  assign query_go = cmd_i.accept && (opcode_i == OP_QUERY);

  // particle store
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && (opcode_i == OP_LOAD) && slot_ok) begin
      mem[AW'(slot_i)] <= {mass_i, pos_y_i, pos_x_i};
    end
    if (cmd_i.rd) begin
      rd_q <= mem[idx_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (query_go) begin
      idx_q <= '0;
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  assign sx = rd_q[POS_W-1:0];
  assign sy = rd_q[2*POS_W-1:POS_W];
  assign sm = rd_q[ENT_W-1:2*POS_W];

  assign rx_w = {sx[POS_W-1], sx} - {px_q[POS_W-1], px_q};
  assign ry_w = {sy[POS_W-1], sy} - {py_q[POS_W-1], py_q};
  assign ax_w = rx_w[DIFF_W-1] ? MAG_W'(-rx_w) : MAG_W'(rx_w);
  assign ay_w = ry_w[DIFF_W-1] ? MAG_W'(-ry_w) : MAG_W'(ry_w);

  // multiplier operand selection
  always_comb begin
    case (cmd_i.mul_sel)
      MUL_AXAX: begin mul_a = MUL_A_W'(ax_q);   mul_b = MUL_B_W'(ax_q); end
      MUL_AYAY: begin mul_a = MUL_A_W'(ay_q);   mul_b = MUL_B_W'(ay_q); end
      MUL_DD:   begin mul_a = MUL_A_W'(d_q);    mul_b = MUL_B_W'(d_q);  end
      MUL_DDD:  begin mul_a = MUL_A_W'(d2_q);   mul_b = MUL_B_W'(d_q);  end
      MUL_G1:   begin mul_a = MUL_A_W'(grav_q); mul_b = MUL_B_W'(sm);   end
      MUL_G2:   begin mul_a = MUL_A_W'(gm_q);   mul_b = MUL_B_W'(pm_q); end
      MUL_PX:   begin mul_a = MUL_A_W'(gm_q);   mul_b = MUL_B_W'(ax_q); end
      MUL_PY:   begin mul_a = MUL_A_W'(gm_q);   mul_b = MUL_B_W'(ay_q); end
      default:  begin mul_a = '0;               mul_b = '0;             end
    endcase
  end

  nbdg_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (cmd_i.mul_go),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .p_o    (mul_p),
    .done_o (mul_done)
  );

  nbdg_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (cmd_i.sqrt_go),
    .rad_i  (RAD_W'(sq_q)),
    .root_o (sqrt_root),
    .done_o (sqrt_done)
  );

  nbdg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (cmd_i.div_go),
    .p_i    (p_q),
    .den_i  (den_q),
    .q_o    (div_q),
    .sat_o  (div_sat),
    .done_o (div_done)
  );

  // saturating accumulation of one term
  always_comb begin
    term_w  = $signed({2'b00, div_q});
    if (cmd_i.div_y ? ry_neg_q : rx_neg_q) begin
      term_w = -term_w;
    end
    acc_ext = cmd_i.div_y ? $signed({fy_q[FORCE_W-1], fy_q})
                          : $signed({fx_q[FORCE_W-1], fx_q});
    sum_w   = acc_ext + term_w;
    ovf     = sum_w[FORCE_W] != sum_w[FORCE_W-1];
    if (ovf) begin
      sum_sat = sum_w[FORCE_W] ? F_NEG_MIN : F_POS_MAX;
    end else begin
      sum_sat = sum_w[FORCE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      px_q <= pos_x_i;
      py_q <= pos_y_i;
      pm_q <= mass_i;
    end
    if (query_go) begin
      fx_q  <= '0;
      fy_q  <= '0;
      sat_q <= 1'b0;
    end else if (div_done) begin
      if (cmd_i.div_y) begin
        fy_q <= $signed(sum_sat);
      end else begin
        fx_q <= $signed(sum_sat);
      end
      sat_q <= sat_q | div_sat | ovf;
    end
    if (cmd_i.diff) begin
      ax_q     <= ax_w;
      ay_q     <= ay_w;
      rx_neg_q <= rx_w[DIFF_W-1];
      ry_neg_q <= ry_w[DIFF_W-1];
    end
    if (sqrt_done) begin
      d_q <= D_W'(sqrt_root) + D_W'(soft_q);
    end
    if (mul_done) begin
      case (cmd_i.mul_sel)
        MUL_AXAX: sq_q  <= SQ_W'(mul_p);
        MUL_AYAY: sq_q  <= sq_q + SQ_W'(mul_p);
        MUL_DD:   d2_q  <= D2_W'(mul_p);
        MUL_DDD:  den_q <= DEN_W'(mul_p);
        MUL_G1:   gm_q  <= GM_W'(GM1_W'(mul_p));
        MUL_G2:   gm_q  <= GM_W'(mul_p);
        MUL_PX:   p_q   <= P_W'(mul_p);
        MUL_PY:   p_q   <= P_W'(mul_p);
        default: ;
      endcase
    end
  end

  assign status_o.last      = idx_q == n_w;
  assign status_o.skip      = (sx == px_q) && (sy == py_q) && (sm == pm_q);
  assign status_o.d_zero    = d_q == '0;
  assign status_o.mul_done  = mul_done;
  assign status_o.sqrt_done = sqrt_done;
  assign status_o.div_done  = div_done;

  assign force_x_o   = fx_q;
  assign force_y_o   = fy_q;
  assign saturated_o = sat_q;

endmodule

// ----- design/nbdg_ctrl.sv -----
// controller state machine sequencing the per-slot force computation
module nbdg_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              opcode_i,
  input  nbdg_pkg::status_t status_i,
  output nbdg_pkg::cmd_t    cmd_o,
  output logic              busy_o,
  output logic              done_o
);
  import nbdg_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_NEXT = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;
  localparam logic [3:0] S_AXAX = 4'd3;
  localparam logic [3:0] S_AYAY = 4'd4;
  localparam logic [3:0] S_SQRT = 4'd5;
  localparam logic [3:0] S_CHKD = 4'd6;
  localparam logic [3:0] S_DD   = 4'd7;
  localparam logic [3:0] S_DDD  = 4'd8;
  localparam logic [3:0] S_G1   = 4'd9;
  localparam logic [3:0] S_G2   = 4'd10;
  localparam logic [3:0] S_PX   = 4'd11;
  localparam logic [3:0] S_DIVX = 4'd12;
  localparam logic [3:0] S_PY   = 4'd13;
  localparam logic [3:0] S_DIVY = 4'd14;
  localparam logic [3:0] S_DONE = 4'd15;

  logic [3:0] state_q, state_d;
  logic       launched_q, launched_d;
  logic [2:0] sel;
  logic [3:0] mul_next;

  always_comb begin
    case (state_q)
      S_AXAX:  begin sel = MUL_AXAX; mul_next = S_AYAY; end
      S_AYAY:  begin sel = MUL_AYAY; mul_next = S_SQRT; end
      S_DD:    begin sel = MUL_DD;   mul_next = S_DDD;  end
      S_DDD:   begin sel = MUL_DDD;  mul_next = S_G1;   end
      S_G1:    begin sel = MUL_G1;   mul_next = S_G2;   end
      S_G2:    begin sel = MUL_G2;   mul_next = S_PX;   end
      S_PX:    begin sel = MUL_PX;   mul_next = S_DIVX; end
      S_PY:    begin sel = MUL_PY;   mul_next = S_DIVY; end
      default: begin sel = MUL_AXAX; mul_next = S_IDLE; end
    endcase
  end

  always_comb begin
    state_d       = state_q;
    launched_d    = launched_q;
    cmd_o         = '0;
    cmd_o.mul_sel = sel;
    done_o        = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.accept = 1'b1;
          if (opcode_i == OP_QUERY) state_d = S_NEXT;
        end
      end
      S_NEXT: begin
        if (status_i.last) begin
          state_d = S_DONE;
        end else begin
          cmd_o.rd = 1'b1;
          state_d  = S_RD;
        end
      end
      S_RD: begin
        if (status_i.skip) begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_NEXT;
        end else begin
          cmd_o.diff = 1'b1;
          state_d    = S_AXAX;
        end
      end
      S_AXAX, S_AYAY, S_DD, S_DDD, S_G1, S_G2, S_PX, S_PY: begin
        if (!launched_q) begin
          cmd_o.mul_go = 1'b1;
          launched_d   = 1'b1;
        end else if (status_i.mul_done) begin
          launched_d = 1'b0;
          state_d    = mul_next;
        end
      end
      S_SQRT: begin
        if (!launched_q) begin
          cmd_o.sqrt_go = 1'b1;
          launched_d    = 1'b1;
        end else if (status_i.sqrt_done) begin
          launched_d = 1'b0;
          state_d    = S_CHKD;
        end
      end
      S_CHKD: begin
        if (status_i.d_zero) begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_NEXT;
        end else begin
          state_d = S_DD;
        end
      end
      S_DIVX, S_DIVY: begin
        cmd_o.div_y = state_q == S_DIVY;
        if (!launched_q) begin
          cmd_o.div_go = 1'b1;
          launched_d   = 1'b1;
        end else if (status_i.div_done) begin
          launched_d = 1'b0;
          if (state_q == S_DIVY) begin
            cmd_o.idx_inc = 1'b1;
            state_d       = S_NEXT;
          end else begin
            state_d = S_PY;
          end
        end
      end
      S_DONE: begin
        done_o  = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      launched_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      launched_q <= launched_d;
    end
  end

  assign busy_o = state_q != S_IDLE;

endmodule

// ----- design/nbody_direct_gravity_force.sv -----
// top level of the 2-D direct-sum softened gravity force engine
// An item is taken when start is high and busy is low. A load item writes one particle
// into its slot and leaves busy low, so loads can follow back to back. A query item
// raises busy and walks slots 0 to count-1 (count capped at MAX_PARTICLES) through one
// shared multi-cycle multiplier, a bit-serial square root and a bit-serial divider; a
// clamped term skips its divide loop, a zero softened distance ends the slot after the
// root, and a slot equal to the query particle is skipped. The result is on force_x_o,
// force_y_o and saturated_o with done_o high for a single cycle, and is held until the
// next query is taken; the receiver cannot stall it. Write configuration only while busy
// is low. Slots hold nothing meaningful until loaded and are not cleared after reset.
module nbody_direct_gravity_force #(
  parameter int MAX_PARTICLES = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                opcode_i,
  input  logic [nbdg_pkg::SLOT_W-1:0]         slot_i,
  input  logic signed [nbdg_pkg::POS_W-1:0]   pos_x_i,
  input  logic signed [nbdg_pkg::POS_W-1:0]   pos_y_i,
  input  logic [nbdg_pkg::MASS_W-1:0]         mass_i,
  input  logic                                cfg_we_i,
  input  logic [nbdg_pkg::CFG_AW-1:0]         cfg_addr_i,
  input  logic [nbdg_pkg::CFG_W-1:0]          cfg_wdata_i,
  output logic                                done_o,
  output logic signed [nbdg_pkg::FORCE_W-1:0] force_x_o,
  output logic signed [nbdg_pkg::FORCE_W-1:0] force_y_o,
  output logic                                saturated_o
);
  import nbdg_pkg::*;

  cmd_t    cmd;
  status_t status;

  nbdg_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .opcode_i (opcode_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy),
    .done_o   (done_o)
  );

  nbdg_dp #(
    .MAX_PARTICLES (MAX_PARTICLES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .opcode_i    (opcode_i),
    .slot_i      (slot_i),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .mass_i      (mass_i),
    .force_x_o   (force_x_o),
    .force_y_o   (force_y_o),
    .saturated_o (saturated_o)
  );

  a_done_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("result strobe outside a query");

  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy) else $error("still busy after result");

  a_query_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && opcode_i == OP_QUERY) |=> busy)
    else $error("query item did not start a walk");

  a_load_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && opcode_i == OP_LOAD) |=> (!busy && !done_o))
    else $error("load item disturbed the controller");

endmodule
